@@ rtl/core/kpd_pkg.sv @@
// Package for the keypad debounce and digit entry block.
// Holds shared widths, key codes, phase codes and the segment table.
// No dependencies.
package kpd_pkg;

	localparam int NUM_KEYS_DEF   = 14;
	localparam int NUM_DIGITS_DEF = 8;
	localparam int KEY_IN_W       = 14;	// sampled key levels on the input
	localparam int DIG_W          = 8;	// one segment byte
	localparam int OUT_DIGITS     = 8;	// digit fields in a result
	localparam int IN_TDATA_W     = 16;
	localparam int OUT_TDATA_W    = 88;

	// Key codes
	localparam int NUM_DIGIT_KEYS = 10;
	localparam int KEY_OP         = 10;
	localparam int KEY_LAMP_A     = 11;
	localparam int KEY_CLEAR      = 12;
	localparam int KEY_LAMP_B     = 13;

	// Debounce phases
	typedef logic [1:0] phase_t;
	localparam phase_t PH_RELEASED = 2'd0;
	localparam phase_t PH_DEBOUNCE = 2'd1;
	localparam phase_t PH_PRESSED  = 2'd2;

	localparam logic [DIG_W-1:0] MARKER_CODE = 8'h08;
	localparam logic [DIG_W-1:0] OP_RESET    = 8'h08;
	localparam logic [DIG_W-1:0] OP_DIGIT    = 8'h80;
	localparam logic [DIG_W-1:0] LAMP_RESET  = 8'hFD;
	localparam logic [DIG_W-1:0] LAMP_KEY_A  = 8'hFE;
	localparam logic [DIG_W-1:0] LAMP_CLEAR  = 8'hFD;
	localparam logic [DIG_W-1:0] LAMP_KEY_B  = 8'hFB;

	function automatic logic [DIG_W-1:0] seg_code(input logic [3:0] digit);
		logic [DIG_W-1:0] code;
		case (digit)
			4'd0:    code = 8'h30;
			4'd1:    code = 8'h6D;
			4'd2:    code = 8'h79;
			4'd3:    code = 8'h33;
			4'd4:    code = 8'h5B;
			4'd5:    code = 8'h5F;
			4'd6:    code = 8'h70;
			4'd7:    code = 8'h7F;
			4'd8:    code = 8'h7B;
			4'd9:    code = 8'h7E;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

@@ rtl/core/keypad_debounce_digit_entry.sv @@
// Top level of the keypad debounce and digit entry block.
// Key phases live in a synchronous memory walked one key per cycle.
// Depends on kpd_pkg.
//
// Channel  | Dir | Signals                      | Contents
// ---------+-----+------------------------------+-----------------------------------------
// s_ (in)  | in  | s_tvalid s_tready s_tdata    | one scan tick: key_levels
// m_ (out) | out | m_tvalid m_tready m_tdata    | shown digits, lamp byte, released mask
//
// After its transaction, a scan tick reads each key's phase from the phase memory in turn,
// writes back the last key, then loads the output register. The phase memory's single
// read port is why the keys are walked one at a time.
// The result waits in an output register; the next tick is accepted while it waits, and
// the walk holds in its final cycle only if the previous result is still not taken.
// Reset clears the key valid bits (every key reads as released) and the display store,
// shows the marker and loads the op pattern and lamp byte with their start values.
module keypad_debounce_digit_entry
	import kpd_pkg::*;
#(
	parameter int NUM_KEYS   = NUM_KEYS_DEF,
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,	// [13:0] key_levels, [15:14] zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata	// [63:0] shown_digit_0..7, [71:64] lamp_bits,
						// [85:72] released_mask, [87:86] zero
);

	localparam int KW = $clog2(NUM_KEYS);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q;

	logic [KEY_IN_W-1:0]   lev_q;
	logic [NUM_KEYS-1:0]   lev_ext;
	logic [KW-1:0]         cnt_q;
	logic [NUM_KEYS-1:0]   vld_q;
	logic [NUM_KEYS-1:0]   rel_q;
	logic [KEY_IN_W-1:0]   rel_out;

	// phase memory and its read stage
	phase_t                ph_mem [NUM_KEYS];
	phase_t                ph_rd_s1;
	logic                  vld_s1;
	logic                  proc_s1;
	logic [KW-1:0]         key_s1;
	logic                  rd_en;

	// display and lamp state
	logic [DIG_W-1:0]      dig_q [NUM_DIGITS];
	logic                  marker_q;
	logic [DIG_W-1:0]      op_q;
	logic [DIG_W-1:0]      lamp_q;

	logic                  m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TDATA_W-1:0] res_data;

	phase_t                ph_prev;
	phase_t                ph_next;
	logic                  key_low;
	logic                  released;
	logic                  out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_en    = (state_q == ST_RUN);

	// keys past the input width read as held down
	for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lev
		if (i < KEY_IN_W) begin : g_in
			assign lev_ext[i] = lev_q[i];
		end else begin : g_hi
			assign lev_ext[i] = 1'b0;
		end
	end

	for (genvar i = 0; i < KEY_IN_W; i++) begin : g_rel
		if (i < NUM_KEYS) begin : g_in
			assign rel_out[i] = rel_q[i];
		end else begin : g_abs
			assign rel_out[i] = 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			proc_s1 <= 1'b0;
		end else begin
			proc_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q == KW'(NUM_KEYS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the tick's levels
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) lev_q <= s_tdata[KEY_IN_W-1:0];
	end

	// phase memory: read one key, write back the key held in the read stage
	always_ff @(posedge clk) begin
		if (proc_s1) ph_mem[key_s1] <= ph_next;
		if (rd_en) begin
			ph_rd_s1 <= ph_mem[cnt_q];
			key_s1   <= cnt_q;
		end
	end

	// valid bits: an entry never written reads as released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (rd_en) vld_s1 <= vld_q[cnt_q];
			if (proc_s1) vld_q[key_s1] <= 1'b1;
		end
	end

	// debounce step for the key in flight
	always_comb begin
		ph_prev = vld_s1 ? ph_rd_s1 : PH_RELEASED;
		key_low = !lev_ext[key_s1];
		case (ph_prev)
			PH_RELEASED: ph_next = key_low ? PH_DEBOUNCE : PH_RELEASED;
			PH_DEBOUNCE: ph_next = key_low ? PH_PRESSED : PH_RELEASED;
			PH_PRESSED:  ph_next = key_low ? PH_PRESSED : PH_RELEASED;
			default:     ph_next = ph_prev;
		endcase
		released = proc_s1 && (ph_prev == PH_PRESSED) && !key_low;
	end

	// key actions on the display store, marker, op pattern and lamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIGITS; d++) dig_q[d] <= '0;
			marker_q <= 1'b1;
			op_q     <= OP_RESET;
			lamp_q   <= LAMP_RESET;
			rel_q    <= '0;
		end else begin
			if (s_tvalid && s_tready) rel_q <= '0;
			if (released) begin
				rel_q[key_s1] <= 1'b1;
				if (key_s1 < KW'(NUM_DIGIT_KEYS)) begin
					// shift the store up and insert the new digit
					for (int d = NUM_DIGITS - 1; d > 0; d--) dig_q[d] <= dig_q[d-1];
					dig_q[0] <= seg_code(4'(key_s1));
					marker_q <= 1'b0;
					op_q     <= OP_DIGIT;
					lamp_q   <= ~OP_DIGIT;
				end else if (key_s1 == KW'(KEY_OP)) begin
					if (op_q == OP_DIGIT || op_q == '0) begin
						op_q   <= {OP_RESET[DIG_W-2:0], 1'b0};
						lamp_q <= ~{OP_RESET[DIG_W-2:0], 1'b0};
					end else begin
						op_q   <= {op_q[DIG_W-2:0], 1'b0};
						lamp_q <= ~{op_q[DIG_W-2:0], 1'b0};
					end
				end else if (key_s1 == KW'(KEY_LAMP_A)) begin
					lamp_q <= LAMP_KEY_A;
				end else if (key_s1 == KW'(KEY_CLEAR)) begin
					for (int d = 0; d < NUM_DIGITS; d++) dig_q[d] <= '0;
					marker_q <= 1'b1;
					lamp_q   <= LAMP_CLEAR;
				end else if (key_s1 == KW'(KEY_LAMP_B)) begin
					lamp_q <= LAMP_KEY_B;
				end
			end
		end
	end

	// assemble the result; digits past the store read as zero
	always_comb begin
		res_data = '0;
		for (int d = 0; d < OUT_DIGITS; d++) begin
			if (d < NUM_DIGITS) res_data[d*DIG_W +: DIG_W] = dig_q[d];
		end
		if (marker_q) res_data[DIG_W-1:0] = MARKER_CODE;
		res_data[OUT_DIGITS*DIG_W +: DIG_W]          = lamp_q;
		res_data[(OUT_DIGITS+1)*DIG_W +: KEY_IN_W]   = rel_out;
	end

	// output register: load when the walk ends, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) m_tdata_q <= res_data;
	end

endmodule

@@ sim/keypad_debounce_digit_entry_tb.sv @@
// Self-checking testbench for keypad_debounce_digit_entry: directed table, then random scan ticks.
// Predicts every result in SystemVerilog and checks it field by field at the output stream.
// Depends on kpd_pkg and the keypad_debounce_digit_entry RTL.
module keypad_debounce_digit_entry_tb;
	import kpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIR_N       = 27;	// rows in the directed table
	localparam int RAND_N      = 600;	// random scan ticks after the table
	localparam int HOLD_CYCLES = 600;	// one long receiver hold-off
	localparam int STALL_LIMIT = 6000;	// cycles without any transaction
	localparam int TAIL        = 40;	// settle time after the last result

	// Segment codes of digit keys 0..9, key 0 in the lowest byte
	localparam logic [9:0][DIG_W-1:0] SEGMENT_OF = {
		8'h7E, 8'h7B, 8'h7F, 8'h70, 8'h5F, 8'h5B, 8'h33, 8'h79, 8'h6D, 8'h30
	};

	// Same layout as m_tdata[85:0]: digit 0 lowest, released mask highest
	typedef struct packed {
		logic [KEY_IN_W-1:0]              released;
		logic [DIG_W-1:0]                 lamp;
		logic [OUT_DIGITS-1:0][DIG_W-1:0] digits;
	} scan_result_t;

	typedef struct packed {
		logic [KEY_IN_W-1:0] levels;
		bit                  typed;	// want holds a hand-written result
		scan_result_t        want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;	// [13:0] key_levels, [15:14] zero
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;	// [63:0] shown_digit_0..7, [71:64] lamp_bits,
						// [85:72] released_mask, [87:86] zero

	// Predictor state
	phase_t                           key_phase_q [NUM_KEYS_DEF];
	logic [OUT_DIGITS-1:0][DIG_W-1:0] entry_store;
	logic                             marker_on;
	logic [DIG_W-1:0]                 op_pattern_q;
	logic [DIG_W-1:0]                 lamp_byte;

	scan_result_t pending_results [$];	// predicted results, oldest first
	scan_result_t got_result;
	scan_result_t want_result;
	stim_row_t    dir_rows [DIR_N];
	int           ticks_sent;
	int           fails;

	keypad_debounce_digit_entry uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Assert reset once at the start, release it on a clock edge
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic stim_row_t open_row(input logic [KEY_IN_W-1:0] levels);
		stim_row_t r;
		r = '0;
		r.levels = levels;
		return r;
	endfunction

	// Row whose result is an empty store with the marker on digit 0
	function automatic stim_row_t typed_row(input logic [KEY_IN_W-1:0] levels,
						input logic [DIG_W-1:0] lamp,
						input logic [KEY_IN_W-1:0] released);
		stim_row_t r;
		r = '0;
		r.levels              = levels;
		r.typed               = 1'b1;
		r.want.digits[0]      = MARKER_CODE;
		r.want.lamp           = lamp;
		r.want.released       = released;
		return r;
	endfunction

	// Advance the predictor by one scan tick and return the result it shows
	function automatic scan_result_t advance_keypad(input logic [KEY_IN_W-1:0] levels);
		scan_result_t r;
		phase_t       was;
		logic         down;
		r = '0;
		for (int k = 0; k < NUM_KEYS_DEF; k++) begin
			down = ~levels[k];
			was  = key_phase_q[k];
			case (was)
				PH_RELEASED: key_phase_q[k] = down ? PH_DEBOUNCE : PH_RELEASED;
				PH_DEBOUNCE: key_phase_q[k] = down ? PH_PRESSED : PH_RELEASED;
				PH_PRESSED:  key_phase_q[k] = down ? PH_PRESSED : PH_RELEASED;
				default:     ;	// unused phase: hold it, no event
			endcase
			if (was == PH_PRESSED && !down) begin
				r.released[k] = 1'b1;
				if (k < NUM_DIGIT_KEYS) begin
					// shift the store up and enter the new digit at position 0
					entry_store  = {entry_store[OUT_DIGITS-2:0], SEGMENT_OF[k]};
					marker_on    = 1'b0;
					op_pattern_q = OP_DIGIT;
					lamp_byte    = ~op_pattern_q;
				end else begin
					case (k)
						KEY_OP: begin
							if (op_pattern_q == OP_DIGIT || op_pattern_q == '0)
								op_pattern_q = OP_RESET;
							op_pattern_q = op_pattern_q << 1;
							lamp_byte    = ~op_pattern_q;
						end
						KEY_LAMP_A: lamp_byte = LAMP_KEY_A;
						KEY_CLEAR: begin
							entry_store = '0;
							marker_on   = 1'b1;
							lamp_byte   = LAMP_CLEAR;
						end
						KEY_LAMP_B: lamp_byte = LAMP_KEY_B;
						default:    ;
					endcase
				end
			end
		end
		r.digits = entry_store;
		if (marker_on)
			r.digits[0] = MARKER_CODE;
		r.lamp = lamp_byte;
		return r;
	endfunction

	// Sender: directed table first, then random ticks, in bursts with random gaps
	initial begin : drive
		int                  burst;
		int                  gap;
		int                  flip_odds;
		logic [KEY_IN_W-1:0] lv;
		logic [KEY_IN_W-1:0] held_levels;
		scan_result_t        pred;

		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		ticks_sent = 0;
		for (int k = 0; k < NUM_KEYS_DEF; k++)
			key_phase_q[k] = PH_RELEASED;
		entry_store  = '0;
		marker_on    = 1'b1;
		op_pattern_q = OP_RESET;
		lamp_byte    = LAMP_RESET;

		dir_rows = '{
			typed_row(14'h3FFF, LAMP_RESET, 14'h0000),	// state straight after reset
			typed_row(14'h0000, LAMP_RESET, 14'h0000),	// all keys down: debouncing
			typed_row(14'h0000, LAMP_RESET, 14'h0000),	// all keys pressed
			typed_row(14'h3FFF, LAMP_KEY_B, 14'h3FFF),	// every key released at once
			typed_row(14'h3FFE, LAMP_KEY_B, 14'h0000),	// key 0 bounces
			typed_row(14'h3FFF, LAMP_KEY_B, 14'h0000),	// back up before pressed: no event
			open_row(14'h3C00),				// digit keys 0..9 down
			open_row(14'h3C00),
			open_row(14'h3FFF),				// enter ten digits in index order
			open_row(14'h3BFF),				// op key: 0x80 restarts at 0x10
			open_row(14'h3BFF),
			open_row(14'h3FFF),
			open_row(14'h3BFF),				// op key again: shift left
			open_row(14'h3BFF),
			open_row(14'h3FFF),
			open_row(14'h37FF),				// lamp key A
			open_row(14'h37FF),
			open_row(14'h3FFF),
			open_row(14'h2FFF),				// clear key
			open_row(14'h2FFF),
			typed_row(14'h3FFF, LAMP_CLEAR, 14'h1000),
			typed_row(14'h1FFF, LAMP_CLEAR, 14'h0000),	// lamp key B with the marker shown
			typed_row(14'h1FFF, LAMP_CLEAR, 14'h0000),
			typed_row(14'h3FFF, LAMP_KEY_B, 14'h2000),
			open_row(14'h3BFF),				// op key with the marker shown
			open_row(14'h3BFF),
			open_row(14'h3FFF)
		};

		held_levels = '1;
		flip_odds   = 4;
		burst       = $urandom_range(0, 24);
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (int i = 0; i < DIR_N + RAND_N; i++) begin
			if (i < DIR_N) begin
				lv = dir_rows[i].levels;
			end else begin
				// change the key activity rate every fifty ticks
				if ((i - DIR_N) % 50 == 0)
					flip_odds = $urandom_range(2, 10);
				if ($urandom_range(0, 6) == 0) begin
					lv = KEY_IN_W'($urandom_range(0, 16383));	// noise tick
				end else begin
					for (int k = 0; k < KEY_IN_W; k++)
						if ($urandom_range(1, flip_odds) == 1)
							held_levels[k] = ~held_levels[k];
					lv = held_levels;
				end
			end

			s_tvalid <= 1'b1;
			s_tdata  <= {{(IN_TDATA_W - KEY_IN_W){1'b0}}, lv};
			do @(posedge clk); while (!s_tready);

			// transaction accepted at this edge
			pred = advance_keypad(lv);
			if (i < DIR_N && dir_rows[i].typed)
				pred = dir_rows[i].want;
			pending_results.push_back(pred);
			ticks_sent++;

			if (burst > 0) begin
				burst--;
			end else begin
				burst = $urandom_range(0, 24);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: rotate through stall patterns, with one long hold-off mid-run
	initial begin : receive
		int cyc;
		int hold;
		bit held_off;
		cyc      = 0;
		hold     = 0;
		held_off = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (!held_off && ticks_sent >= 150) begin
				held_off = 1'b1;
				hold     = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				case ((cyc / 256) % 4)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= (cyc % 5 == 0);
					default: m_tready <= (cyc % 64) < 34;
				endcase
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	initial fails = 0;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no prediction waiting: tdata %h", m_tdata);
				fails++;
			end else begin
				want_result = pending_results.pop_front();
				got_result  = scan_result_t'(m_tdata[$bits(scan_result_t)-1:0]);
				for (int d = 0; d < OUT_DIGITS; d++) begin
					if (got_result.digits[d] !== want_result.digits[d]) begin
						$error("shown_digit_%0d: expected %h, got %h", d,
							want_result.digits[d], got_result.digits[d]);
						fails++;
					end
				end
				if (got_result.lamp !== want_result.lamp) begin
					$error("lamp_bits: expected %h, got %h",
						want_result.lamp, got_result.lamp);
					fails++;
				end
				if (got_result.released !== want_result.released) begin
					$error("released_mask: expected %h, got %h",
						want_result.released, got_result.released);
					fails++;
				end
			end
		end
	end

	// Watchdog: end the run if no transaction moves on either side for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/kpd_pkg.sv
rtl/core/keypad_debounce_digit_entry.sv
sim/keypad_debounce_digit_entry_tb.sv
